// ----- src/ard_pkg.sv -----
// shared types and constants for the archive record deframer
package ard_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PATH_W     = 16;
	localparam int unsigned CLEN_W     = 64;
	localparam int unsigned REM_W      = 41;
	localparam int unsigned CNT_W      = 64;
	localparam int unsigned HCNT_W     = 3;
	localparam int unsigned CLEN_BYTES = 8;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CLEN_W-1:0] CONTENT_LIMIT = CLEN_W'(1) << 40;
	localparam logic [CLEN_W-1:0] DIR_MARKER_RST = '1;
	localparam logic [PATH_W-1:0] MAX_PATH_RST = PATH_W'(1024);
	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(CLEN_BYTES - 1);
	localparam logic [1:0]        COMP_MAX = 2'd3;

	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_CASE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOW_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
	localparam logic [BYTE_W-1:0] CH_DEL    = 8'd127;

	localparam logic [CFG_IDX_W-1:0] CFG_DIR_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PATH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP       = 2'd2;

	typedef enum logic [1:0] {
		KIND_IGNORED,
		KIND_HEADER,
		KIND_PATH,
		KIND_CONTENT
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_END,
		ST_PATH_LONG,
		ST_UNSAFE,
		ST_TOO_LARGE,
		ST_STOPPED
	} status_t;

	typedef struct packed {
		logic [PATH_W-1:0] pos;
		logic              first_letter;
		logic [1:0]        comp_len;
		logic              all_dots;
	} path_state_t;

	typedef struct packed {
		path_state_t nxt;
		logic        bad;
		logic        last;
	} path_result_t;

	localparam path_state_t PATH_STATE_INIT = '{
		pos: '0, first_letter: 1'b0, comp_len: 2'd0, all_dots: 1'b1
	};

endpackage

// ----- src/ard_path_check.sv -----
// path safety check for one path byte, with next component state
module ard_path_check (
	input  ard_pkg::path_state_t         cur,
	input  logic [ard_pkg::BYTE_W-1:0]   data_byte,
	input  logic [ard_pkg::PATH_W-1:0]   path_length,
	output ard_pkg::path_result_t        res
);

	logic                        sep;
	logic                        is_letter;
	logic                        dot_only;
	logic                        bad;
	logic [ard_pkg::BYTE_W-1:0]  low;

	assign sep       = (data_byte == ard_pkg::CH_SLASH) || (data_byte == ard_pkg::CH_BSLASH);
	assign low       = data_byte | ard_pkg::CH_CASE;
	assign is_letter = (low >= ard_pkg::CH_LOW_A) && (low <= ard_pkg::CH_LOW_Z);
	assign dot_only  = cur.all_dots && ((cur.comp_len == 2'd1) || (cur.comp_len == 2'd2));

	always_comb begin
		res.nxt = cur;
		bad = 1'b0;
		if (cur.pos == '0) begin
			bad = sep;
			res.nxt.first_letter = is_letter;
		end
		// drive letter only counts when more bytes follow the colon
		if ((cur.pos == ard_pkg::PATH_W'(1)) && cur.first_letter
				&& (data_byte == ard_pkg::CH_COLON) && (path_length > ard_pkg::PATH_W'(2))) begin
			bad = 1'b1;
		end
		if (sep) begin
			if ((cur.comp_len == 2'd0) || dot_only)
				bad = 1'b1;
			res.nxt.comp_len = 2'd0;
			res.nxt.all_dots = 1'b1;
		end else begin
			if ((data_byte < ard_pkg::CH_SPACE) || (data_byte == ard_pkg::CH_DEL))
				bad = 1'b1;
			if (cur.comp_len != ard_pkg::COMP_MAX)
				res.nxt.comp_len = cur.comp_len + 2'd1;
			if (data_byte != ard_pkg::CH_DOT)
				res.nxt.all_dots = 1'b0;
		end
		res.nxt.pos = cur.pos + ard_pkg::PATH_W'(1);
		res.last = (res.nxt.pos == path_length);
		if (res.last && res.nxt.all_dots
				&& ((res.nxt.comp_len == 2'd1) || (res.nxt.comp_len == 2'd2))) begin
			bad = 1'b1;
		end
		res.bad = bad;
	end

endmodule

// ----- src/archive_record_deframer_top.sv -----
// archive record deframer: byte tagging, path checking and record counting
// Takes one archive byte per clock while in_stall is low and returns one tagged
// word per byte through an input register, then a result register. Every byte
// is handled in a single pass through the record state, so a new word can be
// accepted on every clock; in_stall rises only when a finished result sits
// in the result register and the consumer stalls. After a non-zero status the
// block keeps taking words and tags them as ignored until reset. The
// configuration port is always ready and must only be written while idle.
module archive_record_deframer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ard_pkg::BYTE_W-1:0]     data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     byte_kind,
	output logic [ard_pkg::BYTE_W-1:0]     byte_value,
	output logic                           record_done,
	output logic                           record_is_directory,
	output logic [2:0]                     status,
	output logic [ard_pkg::CNT_W-1:0]      files_written,
	output logic [ard_pkg::CNT_W-1:0]      folders_created,
	output logic [ard_pkg::CNT_W-1:0]      bytes_written,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ard_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ard_pkg::CLEN_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		S_PLEN,
		S_PATH,
		S_CLEN,
		S_DATA
	} stage_t;

	// pipeline
	logic                         valid_s1;
	logic [ard_pkg::BYTE_W-1:0]   data_s1;
	logic                         valid_s2;
	ard_pkg::kind_t               kind_s2;
	logic [ard_pkg::BYTE_W-1:0]   value_s2;
	logic                         done_s2;
	logic                         dir_s2;
	logic                         advance;
	logic                         take;

	// configuration
	logic [ard_pkg::CLEN_W-1:0]   dir_marker_q;
	logic [ard_pkg::PATH_W-1:0]   max_path_q;
	logic                         stop_q;

	// record state
	stage_t                       stage_q, stage_d;
	logic [ard_pkg::HCNT_W-1:0]   hcnt_q, hcnt_d;
	logic [ard_pkg::PATH_W-1:0]   path_len_q, path_len_d;
	ard_pkg::path_state_t         pst_q, pst_d;
	logic [ard_pkg::CLEN_W-1:0]   clen_q, clen_d;
	logic [ard_pkg::REM_W-1:0]    rem_q, rem_d;
	ard_pkg::status_t             sticky_q, sticky_d;
	logic [ard_pkg::CNT_W-1:0]    file_cnt_q, file_cnt_d;
	logic [ard_pkg::CNT_W-1:0]    folder_cnt_q, folder_cnt_d;
	logic [ard_pkg::CNT_W-1:0]    byte_cnt_q, byte_cnt_d;

	ard_pkg::kind_t               kind_d;
	logic                         done_d;
	logic                         dir_d;
	logic                         clear_rec;
	logic [ard_pkg::PATH_W-1:0]   plen_full;
	logic [ard_pkg::CLEN_W-1:0]   clen_new;
	ard_pkg::path_result_t        pres;

	assign advance   = !valid_s2 || !out_stall;
	assign take      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign plen_full = {data_s1, path_len_q[ard_pkg::BYTE_W-1:0]};
	assign clen_new  = {data_s1, clen_q[ard_pkg::CLEN_W-1:ard_pkg::BYTE_W]};

	ard_path_check u_path_check (
		.cur         (pst_q),
		.data_byte   (data_s1),
		.path_length (path_len_q),
		.res         (pres)
	);

	always_comb begin
		stage_d      = stage_q;
		hcnt_d       = hcnt_q;
		path_len_d   = path_len_q;
		pst_d        = pst_q;
		clen_d       = clen_q;
		rem_d        = rem_q;
		sticky_d     = sticky_q;
		file_cnt_d   = file_cnt_q;
		folder_cnt_d = folder_cnt_q;
		byte_cnt_d   = byte_cnt_q;
		kind_d       = ard_pkg::KIND_IGNORED;
		done_d       = 1'b0;
		dir_d        = 1'b0;
		clear_rec    = 1'b0;
		if (sticky_q == ard_pkg::ST_OK) begin
			unique case (stage_q)
				S_PLEN: begin
					kind_d = ard_pkg::KIND_HEADER;
					if (hcnt_q == '0) begin
						path_len_d = {{ard_pkg::BYTE_W{1'b0}}, data_s1};
						hcnt_d = ard_pkg::HCNT_W'(1);
					end else begin
						path_len_d = plen_full;
						hcnt_d = '0;
						if (plen_full == '0) begin
							sticky_d = ard_pkg::ST_END;
						end else if (plen_full > max_path_q) begin
							sticky_d = ard_pkg::ST_PATH_LONG;
						end else begin
							stage_d = S_PATH;
							pst_d = ard_pkg::PATH_STATE_INIT;
						end
					end
				end
				S_PATH: begin
					kind_d = ard_pkg::KIND_PATH;
					pst_d = pres.nxt;
					if (pres.bad) begin
						sticky_d = ard_pkg::ST_UNSAFE;
					end else if (pres.last) begin
						stage_d = S_CLEN;
						hcnt_d = '0;
						clen_d = '0;
					end
				end
				S_CLEN: begin
					kind_d = ard_pkg::KIND_HEADER;
					clen_d = clen_new;
					hcnt_d = hcnt_q + ard_pkg::HCNT_W'(1);
					if (hcnt_q == ard_pkg::HCNT_LAST) begin
						// marker is tested before the size limit
						if (clen_new == dir_marker_q) begin
							folder_cnt_d = folder_cnt_q + ard_pkg::CNT_W'(1);
							done_d = 1'b1;
							dir_d = 1'b1;
							clear_rec = 1'b1;
						end else if (clen_new > ard_pkg::CONTENT_LIMIT) begin
							sticky_d = ard_pkg::ST_TOO_LARGE;
						end else if (clen_new == '0) begin
							done_d = 1'b1;
							file_cnt_d = file_cnt_q + ard_pkg::CNT_W'(1);
							if (stop_q)
								sticky_d = ard_pkg::ST_STOPPED;
							else
								clear_rec = 1'b1;
						end else begin
							rem_d = clen_new[ard_pkg::REM_W-1:0];
							stage_d = S_DATA;
						end
					end
				end
				S_DATA: begin
					kind_d = ard_pkg::KIND_CONTENT;
					byte_cnt_d = byte_cnt_q + ard_pkg::CNT_W'(1);
					rem_d = rem_q - ard_pkg::REM_W'(1);
					if (rem_d == '0) begin
						done_d = 1'b1;
						file_cnt_d = file_cnt_q + ard_pkg::CNT_W'(1);
						if (stop_q)
							sticky_d = ard_pkg::ST_STOPPED;
						else
							clear_rec = 1'b1;
					end
				end
			endcase
		end
		if (clear_rec) begin
			stage_d    = S_PLEN;
			hcnt_d     = '0;
			path_len_d = '0;
			pst_d      = ard_pkg::PATH_STATE_INIT;
			clen_d     = '0;
			rem_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			data_s1      <= '0;
			valid_s2     <= 1'b0;
			kind_s2      <= ard_pkg::KIND_IGNORED;
			value_s2     <= '0;
			done_s2      <= 1'b0;
			dir_s2       <= 1'b0;
			dir_marker_q <= ard_pkg::DIR_MARKER_RST;
			max_path_q   <= ard_pkg::MAX_PATH_RST;
			stop_q       <= 1'b0;
			stage_q      <= S_PLEN;
			hcnt_q       <= '0;
			path_len_q   <= '0;
			pst_q        <= ard_pkg::PATH_STATE_INIT;
			clen_q       <= '0;
			rem_q        <= '0;
			sticky_q     <= ard_pkg::ST_OK;
			file_cnt_q   <= '0;
			folder_cnt_q <= '0;
			byte_cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ard_pkg::CFG_DIR_MARKER: dir_marker_q <= cfg_data;
					ard_pkg::CFG_MAX_PATH:   max_path_q <= cfg_data[ard_pkg::PATH_W-1:0];
					ard_pkg::CFG_STOP:       stop_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
				if (in_valid)
					data_s1 <= data_byte;
			end
			if (advance)
				valid_s2 <= valid_s1;
			if (take) begin
				kind_s2      <= kind_d;
				value_s2     <= data_s1;
				done_s2      <= done_d;
				dir_s2       <= dir_d;
				stage_q      <= stage_d;
				hcnt_q       <= hcnt_d;
				path_len_q   <= path_len_d;
				pst_q        <= pst_d;
				clen_q       <= clen_d;
				rem_q        <= rem_d;
				sticky_q     <= sticky_d;
				file_cnt_q   <= file_cnt_d;
				folder_cnt_q <= folder_cnt_d;
				byte_cnt_q   <= byte_cnt_d;
			end
		end
	end

	assign out_valid           = valid_s2;
	assign byte_kind           = kind_s2;
	assign byte_value          = value_s2;
	assign record_done         = done_s2;
	assign record_is_directory = dir_s2;
	assign status              = sticky_q;
	assign files_written       = file_cnt_q;
	assign folders_created     = folder_cnt_q;
	assign bytes_written       = byte_cnt_q;

	a_dir_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_is_directory |-> record_done && (byte_kind == ard_pkg::KIND_HEADER))
		else $error("directory flag without a completed header word");

	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ard_pkg::ST_OK) |=> (sticky_q == $past(sticky_q)))
		else $error("sticky status changed");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ard_pkg::ST_OK) |=> $stable(file_cnt_q) && $stable(folder_cnt_q)
			&& $stable(byte_cnt_q))
		else $error("counter moved after a sticky status");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

	a_ignored_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		take && (sticky_q != ard_pkg::ST_OK) |=> (kind_s2 == ard_pkg::KIND_IGNORED) && !done_s2)
		else $error("word tagged after a sticky status");

endmodule

// ----- sim/tb.sv -----
// testbench for the archive record deframer, checked word by word against a predictor
`timescale 1ns / 100ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [ard_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [ard_pkg::BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;

	typedef enum logic [1:0] {
		AT_PLEN,
		AT_PATH,
		AT_CLEN,
		AT_DATA
	} stage_t;

	typedef struct packed {
		ard_pkg::kind_t                kind;
		logic [ard_pkg::BYTE_W-1:0]    value;
		logic                          done;
		logic                          is_dir;
		ard_pkg::status_t              st;
		logic [ard_pkg::CNT_W-1:0]     files;
		logic [ard_pkg::CNT_W-1:0]     folders;
		logic [ard_pkg::CNT_W-1:0]     bytes;
	} deframed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ard_pkg::BYTE_W-1:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] byte_kind;
	logic [ard_pkg::BYTE_W-1:0] byte_value;
	logic record_done;
	logic record_is_directory;
	logic [2:0] status;
	logic [ard_pkg::CNT_W-1:0] files_written;
	logic [ard_pkg::CNT_W-1:0] folders_created;
	logic [ard_pkg::CNT_W-1:0] bytes_written;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ard_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ard_pkg::CLEN_W-1:0] cfg_data = '0;

	// predictor state
	logic [ard_pkg::CLEN_W-1:0] dir_marker = ard_pkg::DIR_MARKER_RST;
	logic [ard_pkg::PATH_W-1:0] max_plen = ard_pkg::MAX_PATH_RST;
	logic stop_file = 1'b0;
	stage_t cur_stage = AT_PLEN;
	logic [ard_pkg::HCNT_W-1:0] hdr_cnt = '0;
	logic [ard_pkg::PATH_W-1:0] plen = '0;
	logic [ard_pkg::PATH_W-1:0] ppos = '0;
	logic lead_letter = 1'b0;
	logic [1:0] comp_len = '0;
	logic comp_dots = 1'b1;
	logic [ard_pkg::CLEN_W-1:0] clen_shift = '0;
	logic [ard_pkg::REM_W-1:0] content_left = '0;
	ard_pkg::status_t sticky = ard_pkg::ST_OK;
	logic [ard_pkg::CNT_W-1:0] n_files = '0;
	logic [ard_pkg::CNT_W-1:0] n_folders = '0;
	logic [ard_pkg::CNT_W-1:0] n_bytes = '0;

	deframed_t pending_tags[$];
	logic [ard_pkg::BYTE_W-1:0] path_buf[$];
	int mismatches = 0;
	int words_sent = 0;
	int words_seen = 0;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	archive_record_deframer_top uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.byte_kind           (byte_kind),
		.byte_value          (byte_value),
		.record_done         (record_done),
		.record_is_directory (record_is_directory),
		.status              (status),
		.files_written       (files_written),
		.folders_created     (folders_created),
		.bytes_written       (bytes_written),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_record();
		cur_stage = AT_PLEN;
		hdr_cnt = '0;
		plen = '0;
		ppos = '0;
		lead_letter = 1'b0;
		comp_len = '0;
		comp_dots = 1'b1;
		clen_shift = '0;
		content_left = '0;
	endfunction

	function automatic void close_file();
		n_files = n_files + 1'b1;
		if (stop_file)
			sticky = ard_pkg::ST_STOPPED;
		else
			restart_record();
	endfunction

	function automatic deframed_t deframe_byte(input logic [ard_pkg::BYTE_W-1:0] b);
		deframed_t r;
		logic sep;
		logic dot_only;
		logic bad;
		r = '0;
		r.kind = ard_pkg::KIND_IGNORED;
		r.value = b;
		if (sticky == ard_pkg::ST_OK) begin
			case (cur_stage)
			AT_PLEN: begin
				r.kind = ard_pkg::KIND_HEADER;
				if (hdr_cnt == '0) begin
					plen = {8'd0, b};
					hdr_cnt = ard_pkg::HCNT_W'(1);
				end else begin
					plen = {b, plen[7:0]};
					hdr_cnt = '0;
					if (plen == '0)
						sticky = ard_pkg::ST_END;
					else if (plen > max_plen)
						sticky = ard_pkg::ST_PATH_LONG;
					else begin
						cur_stage = AT_PATH;
						ppos = '0;
						lead_letter = 1'b0;
						comp_len = '0;
						comp_dots = 1'b1;
					end
				end
			end
			AT_PATH: begin
				r.kind = ard_pkg::KIND_PATH;
				sep = (b == ard_pkg::CH_SLASH) || (b == ard_pkg::CH_BSLASH);
				dot_only = comp_dots && comp_len >= 2'd1 && comp_len <= 2'd2;
				bad = 1'b0;
				if (ppos == '0) begin
					bad = sep;
					lead_letter = ((b | ard_pkg::CH_CASE) >= ard_pkg::CH_LOW_A)
						&& ((b | ard_pkg::CH_CASE) <= ard_pkg::CH_LOW_Z);
				end
				if (ppos == 16'd1 && lead_letter && b == ard_pkg::CH_COLON && plen > 16'd2)
					bad = 1'b1;
				if (sep) begin
					if (comp_len == '0 || dot_only)
						bad = 1'b1;
					comp_len = '0;
					comp_dots = 1'b1;
				end else begin
					if (b < ard_pkg::CH_SPACE || b == ard_pkg::CH_DEL)
						bad = 1'b1;
					if (comp_len < ard_pkg::COMP_MAX)
						comp_len = comp_len + 1'b1;
					if (b != ard_pkg::CH_DOT)
						comp_dots = 1'b0;
				end
				ppos = ppos + 1'b1;
				if (ppos == plen && comp_dots && comp_len >= 2'd1 && comp_len <= 2'd2)
					bad = 1'b1;
				if (bad)
					sticky = ard_pkg::ST_UNSAFE;
				else if (ppos == plen) begin
					cur_stage = AT_CLEN;
					hdr_cnt = '0;
					clen_shift = '0;
				end
			end
			AT_CLEN: begin
				r.kind = ard_pkg::KIND_HEADER;
				clen_shift = {b, clen_shift[ard_pkg::CLEN_W-1:8]};
				hdr_cnt = hdr_cnt + 1'b1;
				if (hdr_cnt == '0) begin
					if (clen_shift == dir_marker) begin
						n_folders = n_folders + 1'b1;
						r.done = 1'b1;
						r.is_dir = 1'b1;
						restart_record();
					end else if (clen_shift > ard_pkg::CONTENT_LIMIT)
						sticky = ard_pkg::ST_TOO_LARGE;
					else if (clen_shift == '0) begin
						r.done = 1'b1;
						close_file();
					end else begin
						content_left = clen_shift[ard_pkg::REM_W-1:0];
						cur_stage = AT_DATA;
					end
				end
			end
			default: begin
				r.kind = ard_pkg::KIND_CONTENT;
				n_bytes = n_bytes + 1'b1;
				content_left = content_left - 1'b1;
				if (content_left == '0) begin
					r.done = 1'b1;
					close_file();
				end
			end
			endcase
		end
		r.st = sticky;
		r.files = n_files;
		r.folders = n_folders;
		r.bytes = n_bytes;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at word %0d: %s is %0h, expected %0h", words_seen, field, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		deframed_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tags.size() == 0)
				report_mismatch("word with nothing pending", 64'(byte_value), 64'd0);
			else begin
				want = pending_tags.pop_front();
				if (byte_kind !== want.kind)
					report_mismatch("byte_kind", 64'(byte_kind), 64'(want.kind));
				if (byte_value !== want.value)
					report_mismatch("byte_value", 64'(byte_value), 64'(want.value));
				if (record_done !== want.done)
					report_mismatch("record_done", 64'(record_done), 64'(want.done));
				if (record_is_directory !== want.is_dir)
					report_mismatch("record_is_directory", 64'(record_is_directory),
						64'(want.is_dir));
				if (status !== want.st)
					report_mismatch("status", 64'(status), 64'(want.st));
				if (files_written !== want.files)
					report_mismatch("files_written", files_written, want.files);
				if (folders_created !== want.folders)
					report_mismatch("folders_created", folders_created, want.folders);
				if (bytes_written !== want.bytes)
					report_mismatch("bytes_written", bytes_written, want.bytes);
			end
			words_seen++;
		end
	end

	// consumer stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(input logic [ard_pkg::BYTE_W-1:0] b);
		deframed_t r;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = deframe_byte(b);
		pending_tags.push_back(r);
		if (r.kind != ard_pkg::KIND_IGNORED)
			words_sent++;
	endtask

	// wait for every pending word, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ard_pkg::CFG_IDX_W-1:0] idx,
			input logic [ard_pkg::CLEN_W-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		ard_pkg::CFG_DIR_MARKER: dir_marker = val;
		ard_pkg::CFG_MAX_PATH: max_plen = val[ard_pkg::PATH_W-1:0];
		ard_pkg::CFG_STOP: stop_file = val[0];
		default: ;
		endcase
	endtask

	task automatic send_record(input logic [ard_pkg::CLEN_W-1:0] clen);
		logic [ard_pkg::PATH_W-1:0] n;
		n = ard_pkg::PATH_W'(path_buf.size());
		send_word(n[7:0]);
		send_word(n[15:8]);
		foreach (path_buf[i])
			send_word(path_buf[i]);
		for (int i = 0; i < 8; i++)
			send_word(clen[8*i +: 8]);
		if (clen != dir_marker && clen <= ard_pkg::CONTENT_LIMIT)
			for (longint unsigned k = 0; k < clen; k++)
				send_word(8'($urandom));
	endtask

	// one to three components, none of only one or two dots, no drive letter with bytes after it
	function automatic void make_safe_path();
		int ncomp;
		int clen;
		logic dots;
		logic [ard_pkg::BYTE_W-1:0] c;
		path_buf.delete();
		ncomp = $urandom_range(1, 3);
		for (int i = 0; i < ncomp; i++) begin
			if (i > 0)
				path_buf.push_back($urandom_range(0, 1) ? ard_pkg::CH_SLASH : ard_pkg::CH_BSLASH);
			clen = $urandom_range(1, 4);
			dots = 1'b1;
			for (int j = 0; j < clen; j++) begin
				c = ($urandom_range(0, 4) == 0) ? ard_pkg::CH_DOT : 8'($urandom_range(32, 126));
				if (c == ard_pkg::CH_SLASH || c == ard_pkg::CH_BSLASH)
					c = ard_pkg::CH_DOT;
				if (c != ard_pkg::CH_DOT)
					dots = 1'b0;
				path_buf.push_back(c);
			end
			if (dots && clen <= 2)
				path_buf[path_buf.size() - 1] = CH_UNDERSCORE;
		end
		if ($urandom_range(0, 5) == 0)
			path_buf.push_back(ard_pkg::CH_SLASH);
		if (path_buf.size() > 2 && path_buf[1] == ard_pkg::CH_COLON &&
				(path_buf[0] | ard_pkg::CH_CASE) >= ard_pkg::CH_LOW_A &&
				(path_buf[0] | ard_pkg::CH_CASE) <= ard_pkg::CH_LOW_Z)
			path_buf[1] = CH_UNDERSCORE;
	endfunction

	task automatic send_random_record();
		logic [ard_pkg::CLEN_W-1:0] len;
		make_safe_path();
		case ($urandom_range(0, 15))
		0, 1: len = dir_marker;
		2: len = ard_pkg::CLEN_W'($urandom_range(13, 64));
		default: len = ard_pkg::CLEN_W'($urandom_range(0, 12));
		endcase
		send_record(len);
		if ($urandom_range(0, 60) == 0)
			settle();
	endtask

	task automatic test_directed();
		// zero-length file with a two-byte path that looks like a drive
		path_buf = '{"X", ard_pkg::CH_COLON};
		send_record(64'd0);
		// directory at the reset marker, trailing separator
		path_buf = '{"a", ard_pkg::CH_SLASH};
		send_record(dir_marker);
		settle();
	endtask

	task automatic test_register_settings();
		gap_pct = 15;
		stall_pct = 15;
		write_reg(CFG_UNUSED, '1);
		path_buf = '{ard_pkg::CH_DOT, ard_pkg::CH_DOT, ard_pkg::CH_DOT};
		send_record(64'd2);
		write_reg(ard_pkg::CFG_DIR_MARKER, '0);
		make_safe_path();
		send_record(64'd0);
		make_safe_path();
		send_record(64'd3);
		write_reg(ard_pkg::CFG_DIR_MARKER, ard_pkg::CONTENT_LIMIT + 64'd1);
		make_safe_path();
		send_record(ard_pkg::CONTENT_LIMIT + 64'd1);
		write_reg(ard_pkg::CFG_MAX_PATH, 64'd1);
		path_buf = '{"q"};
		send_record(64'd1);
		write_reg(ard_pkg::CFG_MAX_PATH, 64'd7);
		path_buf = '{"a", "b", "c", ard_pkg::CH_BSLASH, "d", "e", "f"};
		send_record(64'd4);
		write_reg(ard_pkg::CFG_MAX_PATH, 64'hFFFF);
		write_reg(ard_pkg::CFG_STOP, 64'd1);
		repeat (3) begin
			make_safe_path();
			send_record(dir_marker);
		end
		write_reg(ard_pkg::CFG_STOP, 64'd0);
		write_reg(ard_pkg::CFG_DIR_MARKER, '1);
	endtask

	task automatic test_random_records();
		int target;
		int phase_end;
		int phase;
		logic [ard_pkg::CLEN_W-1:0] val;
		target = words_sent + 1850;
		phase = 0;
		while (words_sent < target) begin
			phase_end = words_sent + 250;
			if (target - words_sent <= 300) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case (phase % 4)
				0: begin gap_pct = 20; stall_pct = 20; end
				1: begin gap_pct = 0; stall_pct = 0; end
				2: begin gap_pct = 30; stall_pct = 0; end
				default: begin gap_pct = 0; stall_pct = 30; end
				endcase
			end
			while (words_sent < phase_end && words_sent < target)
				send_random_record();
			case ($urandom_range(0, 3))
			0: val = '1;
			1: val = ard_pkg::CLEN_W'($urandom_range(0, 12));
			2: val = {$urandom, $urandom} | (ard_pkg::CONTENT_LIMIT << 1);
			default: val = {$urandom, $urandom};
			endcase
			write_reg(ard_pkg::CFG_DIR_MARKER, val);
			case ($urandom_range(0, 2))
			0: val = 64'd15;
			1: val = 64'hFFFF;
			default: val = ard_pkg::CLEN_W'($urandom_range(15, 65535));
			endcase
			write_reg(ard_pkg::CFG_MAX_PATH, val);
			phase++;
		end
	endtask

	// one way of ending decoding, or a run of random words, per run; then words that are ignored once decoding has ended
	task automatic test_termination();
		logic [ard_pkg::CLEN_W-1:0] len;
		logic [ard_pkg::PATH_W-1:0] n;
		gap_pct = 0;
		stall_pct = 0;
		case ($urandom_range(0, 13))
		0: begin
			send_word(8'd0);
			send_word(8'd0);
		end
		1: begin
			if (max_plen == 16'hFFFF)
				write_reg(ard_pkg::CFG_MAX_PATH, ard_pkg::CLEN_W'($urandom_range(1, 1024)));
			n = ard_pkg::PATH_W'($urandom_range(int'(max_plen) + 1, 65535));
			send_word(n[7:0]);
			send_word(n[15:8]);
		end
		2: begin path_buf = '{ard_pkg::CH_SLASH, "a"}; send_record(64'd3); end
		3: begin path_buf = '{ard_pkg::CH_BSLASH, "a"}; send_record(64'd3); end
		4: begin path_buf = '{"c", ard_pkg::CH_COLON, "x"}; send_record(64'd3); end
		5: begin
			path_buf = '{"a", ard_pkg::CH_SLASH, ard_pkg::CH_SLASH, "b"};
			send_record(64'd3);
		end
		6: begin path_buf = '{ard_pkg::CH_DOT, ard_pkg::CH_SLASH, "a"}; send_record(64'd3); end
		7: begin
			path_buf = '{"a", ard_pkg::CH_SLASH, ard_pkg::CH_DOT, ard_pkg::CH_DOT,
				ard_pkg::CH_SLASH, "b"};
			send_record(64'd3);
		end
		8: begin
			path_buf = '{"a", 8'($urandom_range(0, 31)), "b"};
			send_record(64'd3);
		end
		9: begin path_buf = '{"a", ard_pkg::CH_DEL}; send_record(64'd3); end
		10: begin
			path_buf = '{"a", ard_pkg::CH_SLASH, ard_pkg::CH_DOT, ard_pkg::CH_DOT};
			send_record(64'd3);
		end
		11: begin
			make_safe_path();
			len = {$urandom, $urandom} | (ard_pkg::CONTENT_LIMIT << 1);
			if (len == dir_marker)
				len = len ^ 64'd1;
			send_record(len);
		end
		12: begin
			write_reg(ard_pkg::CFG_STOP, 64'd1);
			make_safe_path();
			len = ard_pkg::CLEN_W'($urandom_range(0, 5));
			if (len == dir_marker)
				len = len + 64'd6;
			send_record(len);
		end
		default: begin
			for (int i = 0; i < 60; i++)
				send_word(8'($urandom));
		end
		endcase
		for (int i = 0; i < 24; i++)
			send_word(8'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_settings();
		test_random_records();
		test_termination();
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
src/ard_pkg.sv
src/ard_path_check.sv
src/archive_record_deframer_top.sv
sim/tb.sv
